/* src/tpp_pkg.sv */
// Shared constants, types and elaboration-time tables for the tempered pipe pitch block.
// Holds the temperament offsets, the harmonic log table and the exp2 table.
// No dependencies.
package tpp_pkg;

	localparam int NUM_TEMPERAMENTS = 8;
	localparam int MAX_HARMONIC     = 128;
	localparam int EXP_TABLE_BITS   = 8;

	localparam int NOTE_W   = 7;
	localparam int TRANS_W  = 6;
	localparam int HARM_W   = 8;
	localparam int DEV_W    = 22;
	localparam int IN_W     = 48;
	localparam int FREQ_W   = 25;
	localparam int RATIO_W  = 40;
	localparam int OUT_W    = 72;
	localparam int TSEL_W   = 3;
	localparam int BASE_W   = 20;
	localparam int CFG_W    = 25;
	localparam int CFG_AW   = 2;

	localparam int SND_W    = 9;
	localparam int TOFS_W   = 16;
	localparam int HM_W     = 24;
	localparam int MC_W     = 27;
	localparam int U_W      = 26;
	localparam int OCT_W    = 5;
	localparam int F_W      = 21;
	localparam int P_W      = F_W + EXP_TABLE_BITS;
	localparam int K_W      = EXP_TABLE_BITS;
	localparam int EXP_N    = (1 << EXP_TABLE_BITS) + 1;
	localparam int T_W      = 32;
	localparam int D_W      = 31 - EXP_TABLE_BITS;
	localparam int X_W      = D_W + F_W;
	localparam int Y_W      = X_W - 7;
	localparam int C9_W     = Y_W - 13;
	localparam int YL_W     = Y_W / 2;
	localparam int YH_W     = Y_W - YL_W;
	localparam int PROD_W   = BASE_W + T_W;

	localparam int OCT_SH   = 36;
	localparam int OREC_W   = 16;
	localparam int K_SH     = P_W + 11;
	localparam int KREC_W   = P_W - 9;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [F_W-1:0]    MC_PER_OCT = F_W'(1200000);
	localparam logic [MC_W-1:0]   MC_BIAS    = MC_W'(19200000);
	localparam logic [13:0]       DIV9375    = 14'd9375;
	localparam logic [OREC_W-1:0] OCT_REC    = OREC_W'((64'd1 << OCT_SH) / 64'd1200000);
	localparam logic [KREC_W-1:0] K_REC      = KREC_W'((64'd1 << K_SH) / 64'd1200000);
	localparam logic [C9_W-1:0]   C9_REC     = C9_W'((64'd1 << Y_W) / 64'd9375);
	localparam logic [FREQ_W-1:0]  FREQ_MAX  = '1;
	localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

	typedef enum logic [CFG_AW-1:0] {
		CFG_TEMPER = 2'd0,
		CFG_BASE   = 2'd1,
		CFG_MIN    = 2'd2,
		CFG_MAX    = 2'd3
	} cfg_idx_t;

	typedef logic signed [TOFS_W-1:0] temper_tab_t [0:7][0:11];

	localparam temper_tab_t TEMPER_MC = '{
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
		  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd0, -16'sd9775, -16'sd7820, -16'sd5865, -16'sd9775, -16'sd1955,
		  -16'sd11730, -16'sd3910, -16'sd7820, -16'sd11730, -16'sd3910, -16'sd7820},
		'{16'sd0, -16'sd9775, -16'sd6843, -16'sd5865, -16'sd13686, -16'sd1955,
		  -16'sd9776, -16'sd3422, -16'sd7820, -16'sd10265, -16'sd3910, -16'sd11731},
		'{16'sd0, -16'sd5865, -16'sd3910, -16'sd1955, -16'sd7820, 16'sd1955,
		  -16'sd7820, -16'sd1955, -16'sd3910, -16'sd5865, 16'sd0, -16'sd9775},
		'{16'sd0, -16'sd9775, -16'sd3910, -16'sd5865, -16'sd7820, -16'sd1955,
		  -16'sd11730, -16'sd1955, -16'sd7820, -16'sd5865, -16'sd3910, -16'sd9775},
		'{16'sd0, -16'sd23951, -16'sd6843, 16'sd10265, -16'sd13686, 16'sd3422,
		  -16'sd20529, -16'sd3422, -16'sd27373, -16'sd10265, 16'sd6843, -16'sd17108},
		'{16'sd0, 16'sd13685, 16'sd3910, -16'sd5865, 16'sd7820, -16'sd1955,
		  16'sd11730, 16'sd1955, 16'sd15640, 16'sd5865, -16'sd3910, 16'sd9775},
		'{16'sd0, -16'sd11406, -16'sd3259, 16'sd4888, -16'sd6518, 16'sd1629,
		  -16'sd9776, -16'sd1629, -16'sd13035, -16'sd4888, 16'sd3259, -16'sd8147}
	};

	function automatic logic signed [TOFS_W-1:0] temper_offset(
		input logic [TSEL_W-1:0] sel,
		input logic [3:0] pc
	);
		logic signed [TOFS_W-1:0] r;
		r = '0;
		if (int'(sel) < NUM_TEMPERAMENTS && pc < 4'd12)
			r = TEMPER_MC[sel][pc];
		return r;
	endfunction

	function automatic longint unsigned isqrt64(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		longint unsigned vv;
		r = 0;
		b = 64'd1 << 62;
		vv = v;
		while (b > vv)
			b = b >> 2;
		while (b != 0) begin
			if (vv >= r + b) begin
				vv = vv - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [HM_W-1:0] harm_mc(input int unsigned h);
		int unsigned e;
		longint unsigned x;
		longint unsigned frac;
		longint unsigned l;
		longint lv;
		e = 0;
		while (e < 8 && (h >> (e + 1)) != 0)
			e++;
		x = longint'(h) << (30 - e);
		frac = 0;
		for (int i = 0; i < 30; i++) begin
			x = (x * x) >> 30;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				frac = frac | (64'd1 << (29 - i));
			end
		end
		l = (longint'(e) << 30) | frac;
		lv = longint'((l * 64'd1200000 + (64'd1 << 29)) >> 30) - 64'sd3600000;
		return HM_W'(lv);
	endfunction

	typedef logic signed [HM_W-1:0] harm_tab_t [256];

	function automatic harm_tab_t build_harm();
		harm_tab_t t;
		int unsigned h;
		for (int i = 0; i < 256; i++) begin
			h = (i == 0) ? 8 : i;
			if (h > MAX_HARMONIC)
				h = MAX_HARMONIC;
			t[i] = harm_mc(h);
		end
		return t;
	endfunction

	localparam harm_tab_t HARM_TAB = build_harm();

	typedef logic [T_W-1:0] exp_tab_t [EXP_N];

	function automatic exp_tab_t build_exp();
		exp_tab_t t;
		longint unsigned roots [EXP_TABLE_BITS+1];
		longint unsigned acc;
		roots[0] = 64'd1 << 31;
		for (int i = 1; i <= EXP_TABLE_BITS; i++)
			roots[i] = isqrt64(roots[i-1] << 30);
		for (int k = 0; k < (1 << EXP_TABLE_BITS); k++) begin
			acc = 64'd1 << 30;
			for (int i = 0; i < EXP_TABLE_BITS; i++)
				if (((k >> (EXP_TABLE_BITS - 1 - i)) & 1) != 0)
					acc = (acc * roots[i+1] + (64'd1 << 29)) >> 30;
			t[k] = T_W'(acc);
		end
		t[1 << EXP_TABLE_BITS] = T_W'(64'd1 << 31);
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp();

endpackage

/* src/tempered_pipe_pitch.sv */
// Tempered pipe pitch: one frequency and tuning ratio per note event, with range flag.
// Holds the configuration registers; instantiates tpp_front, tpp_fifo and tpp_back.
// Each input beat gives one output beat, in order, and a new beat is taken every cycle unless
// the front end is held by a full queue. The front end forms the milli-cent offset (note,
// transposition, harmonic, deviation and temperament) in its s1 and s2 registers, a
// four-entry queue decouples it from the back end, and the back end carries each beat
// from queue head through its stage registers to the output register. The back end stalls
// as a whole on m_tready; the front end keeps taking beats until the queue is full.
// There is no clearing pass after reset. Write configuration only while no beat is in
// flight.
module tempered_pipe_pitch import tpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // note[6:0], transpose[12:7], harmonic[20:13], deviation[42:21]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // target_freq[24:0], ratio[64:25], in_range[65], saturated[66]
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	logic [TSEL_W-1:0] temper_sel_q;
	logic [BASE_W-1:0] base_pitch_q;
	logic [FREQ_W-1:0] min_freq_q;
	logic [FREQ_W-1:0] max_freq_q;

	logic           push, full, pop, empty;
	logic [U_W-1:0] push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temper_sel_q <= '0;
			base_pitch_q <= BASE_W'(450560);
			min_freq_q   <= FREQ_W'(16384);
			max_freq_q   <= FREQ_W'(20480000);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_TEMPER: temper_sel_q <= cfg_wdata[TSEL_W-1:0];
				CFG_BASE:   base_pitch_q <= cfg_wdata[BASE_W-1:0];
				CFG_MIN:    min_freq_q   <= cfg_wdata[FREQ_W-1:0];
				CFG_MAX:    max_freq_q   <= cfg_wdata[FREQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tpp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.temper_sel (temper_sel_q),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	tpp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	tpp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_data      (pop_data),
		.empty         (empty),
		.pop           (pop),
		.base_pitch    (base_pitch_q),
		.min_pipe_freq (min_freq_q),
		.max_pipe_freq (max_freq_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

endmodule

/* src/tpp_front.sv */
// Front end: takes input beats and reduces each to a biased milli-cent offset from A4.
// Uses tpp_pkg for the harmonic and temperament tables; feeds tpp_fifo.
module tpp_front import tpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // note[6:0], transpose[12:7], harmonic[20:13], deviation[42:21]
	input  logic [TSEL_W-1:0] temper_sel,
	output logic              push,
	output logic [U_W-1:0]    push_data,
	input  logic              full
);

	logic [NOTE_W-1:0]         note;
	logic signed [TRANS_W-1:0] transpose;
	logic [HARM_W-1:0]         harmonic;
	logic signed [DEV_W-1:0]   deviation;
	logic signed [SND_W-1:0]   snd;
	logic [7:0]                pcv;
	logic [15:0]               pcq;
	logic [7:0]                pcm;
	logic [3:0]                pc;
	logic                      adv;

	logic                      v_s1, v_s2;
	logic signed [SND_W-1:0]   snd_s1;
	logic signed [TOFS_W-1:0]  tofs_s1;
	logic signed [HM_W-1:0]    hmc_s1;
	logic signed [DEV_W-1:0]   dev_s1;
	logic signed [MC_W-1:0]    semi;
	logic signed [MC_W-1:0]    mc;
	logic [U_W-1:0]            u_s2;

	assign note      = s_tdata[6:0];
	assign transpose = s_tdata[12:7];
	assign harmonic  = s_tdata[20:13];
	assign deviation = s_tdata[42:21];

	assign snd = signed'({2'b00, note}) + SND_W'(transpose);
	assign pcv = 8'(snd + 9'sd36);
	assign pcq = (16'(pcv) * 16'd171) >> 11;
	assign pcm = 8'(pcq) * 8'd12;
	assign pc  = 4'(pcv - pcm);

	assign semi = MC_W'(10'(snd_s1) - 10'sd69) * 27'sd100000;
	assign mc   = semi + MC_W'(hmc_s1) + MC_W'(dev_s1) + MC_W'(tofs_s1) + signed'(MC_BIAS);

	assign adv       = !v_s2 || !full;
	assign s_tready  = adv;
	assign push      = v_s2 && !full;
	assign push_data = u_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			snd_s1  <= snd;
			tofs_s1 <= temper_offset(temper_sel, pc);
			hmc_s1  <= HARM_TAB[harmonic];
			dev_s1  <= deviation;
			u_s2    <= U_W'(mc);
		end
	end

endmodule

/* src/tpp_fifo.sv */
// Short queue between front and back end, flop based, show-ahead read.
// Uses tpp_pkg for depth and data width.
module tpp_fifo import tpp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [U_W-1:0] push_data,
	output logic           full,
	input  logic           pop,
	output logic [U_W-1:0] pop_data,
	output logic           empty
);

	logic [U_W-1:0]     mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full     = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_data;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue count beyond depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty)) else $error("queue overrun or underrun");

endmodule

/* src/tpp_back.sv */
// Back end: turns the biased milli-cent offset into ratio, target frequency and flags.
// Uses tpp_pkg for the exp2 table and reciprocal constants; drains tpp_fifo.
module tpp_back import tpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [U_W-1:0]    pop_data,
	input  logic              empty,
	output logic              pop,
	input  logic [BASE_W-1:0] base_pitch,
	input  logic [FREQ_W-1:0] min_pipe_freq,
	input  logic [FREQ_W-1:0] max_pipe_freq,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata    // target_freq[24:0], ratio[64:25], in_range[65], saturated[66]
);

	localparam int NST = 11;

	logic [NST-1:0] vld_q;
	logic           adv;

	logic [U_W+OREC_W-1:0] oprod;
	logic [U_W-1:0]        u_s1;
	logic [OCT_W-1:0]      oest_s1;

	logic [U_W-1:0]   ofs;
	logic [F_W:0]     f0;
	logic [OCT_W-1:0] oct_s2, oct_s3, oct_s4, oct_s5, oct_s6, oct_s7, oct_s8, oct_s9, oct_s10;
	logic [F_W-1:0]   f_s2;

	logic [P_W-1:0]        p;
	logic [P_W+KREC_W-1:0] kprod;
	logic [P_W-1:0]        p_s3;
	logic [K_W-1:0]        kest_s3;

	logic [P_W-1:0] kofs;
	logic [P_W-1:0] r4;
	logic [K_W-1:0] k_s4;
	logic [F_W-1:0] q_s4, q_s5;

	logic [T_W-1:0] t0, t1;
	logic [T_W-1:0] t0_s5, t0_s6, t0_s7, t0_s8;
	logic [D_W-1:0] d_s5;

	logic [X_W-1:0] x6;
	logic [Y_W-1:0] y_s6, y_s7, y_s8;

	logic [YL_W+C9_W-1:0] pl_s7;
	logic [YH_W+C9_W-1:0] ph_s7;

	logic [Y_W+C9_W-1:0] sum8;
	logic [D_W-1:0]      fest_s8;

	logic [Y_W-1:0] fofs;
	logic [Y_W-1:0] r9;
	logic [D_W-1:0] frac;
	logic [T_W-1:0] m_s9, m_s10;

	logic [PROD_W-1:0] prod_s10;

	logic [63:0]          w;
	logic [RATIO_W+2:0]   rraw;
	logic [PROD_W+30:0]   w2;
	logic [PROD_W-15:0]   traw;
	logic [RATIO_W-1:0]   ratio;
	logic [FREQ_W-1:0]    target;
	logic                 rsat, tsat;

	logic [FREQ_W-1:0]  target_q;
	logic [RATIO_W-1:0] ratio_q;
	logic               in_range_q, sat_q;

	assign adv      = !vld_q[NST-1] || m_tready;
	assign pop      = adv && !empty;
	assign m_tvalid = vld_q[NST-1];
	assign m_tdata  = {5'd0, sat_q, in_range_q, ratio_q, target_q};

	assign oprod = pop_data * OCT_REC;

	assign ofs = oest_s1 * MC_PER_OCT;
	assign f0  = (F_W+1)'(u_s1 - ofs);

	assign p     = {f_s2, {EXP_TABLE_BITS{1'b0}}};
	assign kprod = p * K_REC;

	assign kofs = kest_s3 * MC_PER_OCT;
	assign r4   = p_s3 - kofs;

	assign t0 = EXP_TAB[k_s4];
	assign t1 = EXP_TAB[(K_W+1)'(k_s4) + 1'b1];

	assign x6 = d_s5 * q_s5;

	assign sum8 = (Y_W+C9_W)'(pl_s7) + ((Y_W+C9_W)'(ph_s7) << YL_W);

	assign fofs = fest_s8 * DIV9375;
	assign r9   = y_s8 - fofs;
	assign frac = (r9 >= Y_W'(DIV9375)) ? fest_s8 + 1'b1 : fest_s8;

	assign w      = 64'(m_s10) << oct_s10;
	assign rraw   = {1'b0, w[63:22]} + (RATIO_W+3)'(w[21]);
	assign rsat   = rraw > (RATIO_W+3)'(RATIO_MAX);
	assign ratio  = rsat ? RATIO_MAX : RATIO_W'(rraw);
	assign w2     = (PROD_W+31)'(prod_s10) << oct_s10;
	assign traw   = {1'b0, w2[PROD_W+30:46]} + (PROD_W-14)'(w2[45]);
	assign tsat   = traw > (PROD_W-14)'(FREQ_MAX);
	assign target = tsat ? FREQ_MAX : FREQ_W'(traw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], !empty};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1    <= pop_data;
			oest_s1 <= oprod[OCT_SH +: OCT_W];

			if (f0 >= (F_W+1)'(MC_PER_OCT)) begin
				oct_s2 <= oest_s1 + 1'b1;
				f_s2   <= F_W'(f0 - (F_W+1)'(MC_PER_OCT));
			end else begin
				oct_s2 <= oest_s1;
				f_s2   <= F_W'(f0);
			end

			p_s3    <= p;
			kest_s3 <= kprod[K_SH +: K_W];
			oct_s3  <= oct_s2;

			if (r4 >= P_W'(MC_PER_OCT)) begin
				k_s4 <= kest_s3 + 1'b1;
				q_s4 <= F_W'(r4 - P_W'(MC_PER_OCT));
			end else begin
				k_s4 <= kest_s3;
				q_s4 <= F_W'(r4);
			end
			oct_s4 <= oct_s3;

			t0_s5  <= t0;
			d_s5   <= D_W'(t1 - t0);
			q_s5   <= q_s4;
			oct_s5 <= oct_s4;

			y_s6   <= x6[X_W-1:7];
			t0_s6  <= t0_s5;
			oct_s6 <= oct_s5;

			pl_s7  <= y_s6[YL_W-1:0] * C9_REC;
			ph_s7  <= y_s6[Y_W-1:YL_W] * C9_REC;
			y_s7   <= y_s6;
			t0_s7  <= t0_s6;
			oct_s7 <= oct_s6;

			fest_s8 <= sum8[Y_W +: D_W];
			y_s8    <= y_s7;
			t0_s8   <= t0_s7;
			oct_s8  <= oct_s7;

			m_s9   <= t0_s8 + T_W'(frac);
			oct_s9 <= oct_s8;

			prod_s10 <= base_pitch * m_s9;
			m_s10    <= m_s9;
			oct_s10  <= oct_s9;

			target_q   <= target;
			ratio_q    <= ratio;
			in_range_q <= (target >= min_pipe_freq) && (target <= max_pipe_freq);
			sat_q      <= rsat || tsat;
		end
	end

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && sat_q |-> target_q == FREQ_MAX || ratio_q == RATIO_MAX)
		else $error("saturation flag without clipped field");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && in_range_q |-> target_q <= max_pipe_freq)
		else $error("in-range flag with target above maximum");
	a_frac_oct: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[1] |-> f_s2 < MC_PER_OCT) else $error("octave split left remainder too large");
	a_frac_step: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3] |-> q_s4 < MC_PER_OCT) else $error("table split left remainder too large");

endmodule

/* sim/tempered_pipe_pitch_tb.sv */
// Testbench for tempered_pipe_pitch: directed table then randomised note beats over phases
// of register settings, each output beat checked against a listed expectation or an in-bench pitch predictor.
// Depends on tpp_pkg and tempered_pipe_pitch from src.
module tempered_pipe_pitch_tb;
	import tpp_pkg::*;

	localparam int  CYCLE_LIMIT  = 400000;
	localparam int  DRAIN_CYCLES = 40;
	localparam longint MC_OCT    = 1200000;

	typedef struct {
		logic [FREQ_W-1:0]  target_freq;
		logic [RATIO_W-1:0] ratio;
		logic               in_range;
		logic               saturated;
	} pitch_t;

	typedef struct {
		logic [6:0]         note;
		logic signed [5:0]  transpose;
		logic [7:0]         harmonic;
		logic signed [21:0] deviation;
		bit                 typed;
		pitch_t             want;
	} note_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = CFG_TEMPER;
	logic [CFG_W-1:0] cfg_wdata = '0;

	logic [TSEL_W-1:0] temper_sel;
	logic [BASE_W-1:0] base_freq;
	logic [FREQ_W-1:0] min_freq;
	logic [FREQ_W-1:0] max_freq;

	longint unsigned exp_q30 [EXP_N];
	longint          harm_cents [MAX_HARMONIC+1];
	pitch_t          pitch_q [$];
	int              errors = 0;
	int              cycles = 0;
	int              notes_sent = 0;
	int              pitches_seen = 0;
	int              sat_seen = 0;
	int              out_range_seen = 0;
	bit              quiet = 1'b0;
	int              stall_left = 0;

	tempered_pipe_pitch uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[tempered_pipe_pitch] ERROR");
			$finish;
		end
	end

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint octave_cents(input int unsigned h);
		int unsigned e;
		longint unsigned x;
		longint unsigned frac;
		longint unsigned lg;
		e = 0;
		frac = 0;
		while (e < 8 && (h >> (e + 1)) != 0)
			e++;
		x = longint'(h) << (30 - e);
		for (int i = 0; i < 30; i++) begin
			x = (x * x) >> 30;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				frac = frac | (64'd1 << (29 - i));
			end
		end
		lg = (longint'(e) << 30) | frac;
		return longint'((lg * 64'd1200000 + (64'd1 << 29)) >> 30) - 3 * MC_OCT;
	endfunction

	function automatic void fill_tables();
		longint unsigned roots [EXP_TABLE_BITS+1];
		longint unsigned acc;
		roots[0] = 64'd1 << 31;
		for (int i = 1; i <= EXP_TABLE_BITS; i++)
			roots[i] = floor_sqrt(roots[i-1] << 30);
		for (int k = 0; k < (1 << EXP_TABLE_BITS); k++) begin
			acc = 64'd1 << 30;
			for (int i = 0; i < EXP_TABLE_BITS; i++)
				if ((k >> (EXP_TABLE_BITS - 1 - i)) & 1)
					acc = (acc * roots[i+1] + (64'd1 << 29)) >> 30;
			exp_q30[k] = acc;
		end
		exp_q30[1 << EXP_TABLE_BITS] = 64'd1 << 31;
		for (int h = 1; h <= MAX_HARMONIC; h++)
			harm_cents[h] = octave_cents(h);
	endfunction

	function automatic longint unsigned shift_clip(input longint unsigned v, input int s,
			input longint unsigned lim, inout bit sat);
		longint unsigned r;
		if (s >= 0) begin
			if (s >= 63 || (v != 0 && v > (lim >> s))) begin
				sat = 1'b1;
				return lim;
			end
			return v << s;
		end
		s = -s;
		if (s >= 64)
			return 0;
		r = (v >> s) + ((v >> (s - 1)) & 1);
		if (r > lim) begin
			sat = 1'b1;
			return lim;
		end
		return r;
	endfunction

	function automatic pitch_t predict_pitch(input logic [6:0] note,
			input logic signed [5:0] transpose, input logic [7:0] harmonic,
			input logic signed [21:0] deviation);
		pitch_t res;
		longint sounding;
		longint pc;
		longint cents;
		longint unsigned u;
		longint unsigned f;
		longint unsigned p;
		longint unsigned q;
		longint unsigned m;
		longint unsigned tgt;
		int k;
		int oct;
		int unsigned h;
		bit sat;
		sat = 1'b0;
		sounding = longint'(note) + longint'(transpose);
		pc = sounding % 12;
		if (pc < 0)
			pc += 12;
		h = 32'(harmonic);
		if (h == 0)
			h = 8;
		if (h > MAX_HARMONIC)
			h = MAX_HARMONIC;
		cents = (sounding - 69) * 100000 + harm_cents[h] + longint'(deviation)
			+ longint'(TEMPER_MC[temper_sel][pc]);
		u = longint'(cents + 16 * MC_OCT);
		oct = int'(u / MC_OCT) - 16;
		f = u % MC_OCT;
		p = f << EXP_TABLE_BITS;
		k = int'(p / MC_OCT);
		q = p % MC_OCT;
		m = exp_q30[k] + ((exp_q30[k+1] - exp_q30[k]) * q) / MC_OCT;
		res.ratio = RATIO_W'(shift_clip(m, oct - 6, RATIO_MAX, sat));
		tgt = shift_clip(longint'(base_freq) * m, oct - 30, FREQ_MAX, sat);
		res.target_freq = FREQ_W'(tgt);
		res.in_range = (tgt >= min_freq && tgt <= max_freq);
		res.saturated = sat;
		return res;
	endfunction

	always @(posedge clk) begin
		if (quiet)
			m_tready <= 1'b1;
		else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		pitch_t want;
		if (arst_n && m_tvalid && m_tready) begin
			pitches_seen++;
			if (m_tdata[66])
				sat_seen++;
			if (!m_tdata[65])
				out_range_seen++;
			if (pitch_q.size() == 0) begin
				$error("unexpected output beat %h", m_tdata);
				errors++;
			end else begin
				want = pitch_q.pop_front();
				if (m_tdata[24:0] !== want.target_freq) begin
					$error("target_freq exp %0d got %0d", want.target_freq, m_tdata[24:0]);
					errors++;
				end
				if (m_tdata[64:25] !== want.ratio) begin
					$error("ratio exp %0d got %0d", want.ratio, m_tdata[64:25]);
					errors++;
				end
				if (m_tdata[65] !== want.in_range) begin
					$error("in_range exp %0b got %0b", want.in_range, m_tdata[65]);
					errors++;
				end
				if (m_tdata[66] !== want.saturated) begin
					$error("saturated exp %0b got %0b", want.saturated, m_tdata[66]);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TEMPER: temper_sel = val[TSEL_W-1:0];
			CFG_BASE:   base_freq = val[BASE_W-1:0];
			CFG_MIN:    min_freq = val[FREQ_W-1:0];
			CFG_MAX:    max_freq = val[FREQ_W-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (pitch_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_note(input note_row_t row);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, row.deviation, row.harmonic, row.transpose, row.note};
		do @(posedge clk); while (!s_tready);
		notes_sent++;
		if (row.typed)
			pitch_q.push_back(row.want);
		else
			pitch_q.push_back(predict_pitch(row.note, row.transpose, row.harmonic,
				row.deviation));
	endtask

	function automatic note_row_t plain(input logic [6:0] n, input logic signed [5:0] t,
			input logic [7:0] h, input logic signed [21:0] d);
		note_row_t r;
		r.note = n;
		r.transpose = t;
		r.harmonic = h;
		r.deviation = d;
		r.typed = 1'b0;
		r.want = '{0, 0, 0, 0};
		return r;
	endfunction

	function automatic note_row_t known(input logic [6:0] n, input logic signed [5:0] t,
			input logic [7:0] h, input logic signed [21:0] d,
			input logic [FREQ_W-1:0] tf, input logic [RATIO_W-1:0] ra);
		note_row_t r;
		r = plain(n, t, h, d);
		r.typed = 1'b1;
		r.want = '{tf, ra, 1'b1, 1'b0};
		return r;
	endfunction

	function automatic note_row_t random_note();
		note_row_t r;
		logic [7:0] h;
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 3))
				0: h = 8'd0;
				1: h = 8'(1 << $urandom_range(0, 7));
				default: h = 8'($urandom_range(0, 128));
			endcase
			r = plain(7'($urandom_range(0, 127)), 6'($urandom_range(0, 48) - 24), h,
				22'($urandom_range(0, 2400000) - 1200000));
		end else
			r = plain(7'($urandom), 6'($urandom), 8'($urandom), 22'($urandom));
		return r;
	endfunction

	initial begin
		note_row_t table_rows [$];
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		fill_tables();
		temper_sel = '0;
		base_freq = 20'd450560;
		min_freq = 25'd16384;
		max_freq = 25'd20480000;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		table_rows = '{
			known(7'd69, 6'sd0, 8'd8, 22'sd0, 25'd450560, 40'd16777216),
			known(7'd69, 6'sd0, 8'd0, 22'sd0, 25'd450560, 40'd16777216),
			known(7'd81, 6'sd0, 8'd8, 22'sd0, 25'd901120, 40'd33554432),
			known(7'd57, 6'sd0, 8'd8, 22'sd0, 25'd225280, 40'd8388608),
			known(7'd69, 6'sd0, 8'd16, 22'sd0, 25'd901120, 40'd33554432),
			known(7'd69, 6'sd0, 8'd8, 22'sd1200000, 25'd901120, 40'd33554432),
			known(7'd69, 6'sd0, 8'd8, -22'sd1200000, 25'd225280, 40'd8388608),
			plain(7'd0, 6'sd0, 8'd8, 22'sd0),
			plain(7'd127, 6'sd0, 8'd8, 22'sd0),
			plain(7'd69, 6'sd24, 8'd8, 22'sd0),
			plain(7'd69, -6'sd24, 8'd8, 22'sd0),
			plain(7'd0, -6'sd32, 8'd1, -22'sd2097152),
			plain(7'd127, 6'sd31, 8'd128, 22'sd2097151),
			plain(7'd69, 6'sd0, 8'd1, 22'sd0),
			plain(7'd69, 6'sd0, 8'd128, 22'sd0),
			plain(7'd69, 6'sd0, 8'd255, 22'sd0),
			plain(7'd60, 6'sd0, 8'd12, 22'sd1),
			plain(7'd61, -6'sd1, 8'd3, -22'sd1),
			plain(7'd42, 6'sd5, 8'd129, 22'sd777777)
		};
		foreach (table_rows[i])
			send_note(table_rows[i]);
		s_tvalid <= 1'b0;
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_TEMPER, CFG_W'(ph));
			case (ph)
				0: write_reg(CFG_BASE, CFG_W'(1));
				1: write_reg(CFG_BASE, CFG_W'(20'hFFFFF));
				2: write_reg(CFG_BASE, CFG_W'(0));
				default: write_reg(CFG_BASE, CFG_W'($urandom_range(1, 1048575)));
			endcase
			case (ph % 4)
				0: begin lo = '0; hi = '1; end
				1: begin lo = 25'd16384; hi = 25'd20480000; end
				2: begin lo = 25'd5000000; hi = 25'd1000; end
				default: begin
					lo = CFG_W'($urandom_range(0, 2000000));
					hi = lo + CFG_W'($urandom_range(0, 20000000));
				end
			endcase
			write_reg(CFG_MIN, lo);
			write_reg(CFG_MAX, hi);
			quiet = (ph == 7);
			for (int n = 0; n < 110; n++) begin
				if (ph == 3 && n == 55) begin
					s_tvalid <= 1'b0;
					while (pitch_q.size() != 0)
						@(posedge clk);
				end
				send_note(random_note());
			end
			s_tvalid <= 1'b0;
			wait_idle();
		end

		$display("sent %0d note beats over 8 register settings, all temperaments",
			notes_sent);
		$display("checked %0d pitches, %0d saturated, %0d outside pipe range",
			pitches_seen, sat_seen, out_range_seen);
		if (errors == 0)
			$display("[tempered_pipe_pitch] OK");
		else
			$display("[tempered_pipe_pitch] ERROR");
		$finish;
	end

endmodule

/* sim.f */
src/tpp_pkg.sv
src/tpp_front.sv
src/tpp_fifo.sv
src/tpp_back.sv
src/tempered_pipe_pitch.sv
sim/tempered_pipe_pitch_tb.sv
